[sv/sha256_pkg.sv]
package sha256_pkg;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic        last;
        logic        finish;
        logic [31:0] word;
    } blk_word_t;

    localparam logic [255:0] INITIAL_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0: k = 32'h428A2F98; 6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF; 6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B; 6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4; 6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98; 6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; default: k = 32'hC67178F2;
        endcase
        return k;
    endfunction

endpackage

[sv/sha256_front.sv]
module sha256_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_item_t  in_data,
    output logic                  wq_valid,
    input  logic                  wq_ready,
    output sha256_pkg::blk_word_t wq_data
);

    typedef enum logic [2:0] {
        F_ABSORB = 3'b001,
        F_PAD    = 3'b010,
        F_LEN    = 3'b100
    } f_state_t;

    f_state_t    state_reg, state_next;
    logic [63:0] count_reg, count_next;
    logic [23:0] acc_reg, acc_next;
    logic [3:0]  widx_reg, widx_next;
    logic        len_hi_reg, len_hi_next;
    logic [63:0] bit_len;
    logic [1:0]  bpos;

    assign bpos    = count_reg[1:0];
    assign bit_len = {count_reg[60:0], 3'b000};

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        widx_next   = widx_reg;
        len_hi_next = len_hi_reg;
        in_ready    = 1'b0;
        wq_valid    = 1'b0;
        wq_data     = '0;
        unique case (state_reg)
            F_ABSORB:
            begin
                if (in_data.op == sha256_pkg::OP_ABSORB)
                begin
                    wq_valid     = in_valid && (bpos == 2'd3);
                    wq_data.word = {acc_reg, in_data.data_byte};
                    wq_data.last = (widx_reg == 4'd15);
                    in_ready     = (bpos != 2'd3) || wq_ready;
                    if (in_valid && in_ready)
                    begin
                        count_next = count_reg + 64'd1;
                        unique case (bpos)
                            2'd0: acc_next = {in_data.data_byte, 16'h0000};
                            2'd1: acc_next[15:8] = in_data.data_byte;
                            2'd2: acc_next[7:0] = in_data.data_byte;
                            default: widx_next = widx_reg + 4'd1;
                        endcase
                    end
                end
                else
                begin
                    wq_valid = in_valid;
                    unique case (bpos)
                        2'd0: wq_data.word = 32'h80000000;
                        2'd1: wq_data.word = {acc_reg[23:16], 24'h800000};
                        2'd2: wq_data.word = {acc_reg[23:8], 16'h8000};
                        default: wq_data.word = {acc_reg, 8'h80};
                    endcase
                    wq_data.last = (widx_reg == 4'd15);
                    if (in_valid && wq_ready)
                    begin
                        widx_next = widx_reg + 4'd1;
                        state_next = (widx_reg == 4'd13) ? F_LEN : F_PAD;
                        len_hi_next = 1'b1;
                    end
                end
            end
            F_PAD:
            begin
                wq_valid     = 1'b1;
                wq_data.word = '0;
                wq_data.last = (widx_reg == 4'd15);
                if (wq_ready)
                begin
                    widx_next = widx_reg + 4'd1;
                    if (widx_reg == 4'd13)
                        state_next = F_LEN;
                end
            end
            default:
            begin
                wq_valid       = 1'b1;
                wq_data.word   = len_hi_reg ? bit_len[63:32] : bit_len[31:0];
                wq_data.last   = !len_hi_reg;
                wq_data.finish = !len_hi_reg;
                if (wq_ready)
                begin
                    widx_next   = widx_reg + 4'd1;
                    len_hi_next = 1'b0;
                    if (!len_hi_reg)
                    begin
                        in_ready   = 1'b1;
                        count_next = '0;
                        state_next = F_ABSORB;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_ABSORB;
            count_reg  <= '0;
            widx_reg   <= '0;
            len_hi_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            widx_reg   <= widx_next;
            len_hi_reg <= len_hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

`ifndef SYNTHESIS
    a_len_at_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_LEN && len_hi_reg) |-> widx_reg == 4'd14)
        else $error("length word out of place");
    a_count_low: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_ABSORB) |-> widx_reg == count_reg[5:2])
        else $error("word index out of step with count");
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        (wq_valid && wq_data.finish) |-> wq_data.last)
        else $error("finish not on block end");
`endif

endmodule

[sv/sha256_queue.sv]
module sha256_queue #(
    parameter int DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  sha256_pkg::blk_word_t wr_data,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output sha256_pkg::blk_word_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::blk_word_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH))
        else $error("queue overflow");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + (AW+1)'(1))
        else $error("queue count slip");
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !pop)
        else $error("pop from empty queue");
`endif

endmodule

[sv/sha256_core.sv]
module sha256_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wq_valid,
    output logic                  wq_ready,
    input  sha256_pkg::blk_word_t wq_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_item_t out_data
);

    typedef enum logic [3:0] {
        C_LOAD  = 4'b0001,
        C_ROUND = 4'b0010,
        C_ADD   = 4'b0100,
        C_EMIT  = 4'b1000
    } c_state_t;

    c_state_t    state_reg;
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [5:0]  t_reg;
    logic        fin_reg;
    logic [2:0]  oidx_reg;
    logic [31:0] wt, s0, s1, t1, t2, e, a, big0, big1, ch, maj, wnew;

    assign wq_ready = (state_reg == C_LOAD);
    assign out_valid = (state_reg == C_EMIT);
    assign out_data.digest_word = h_reg[oidx_reg];
    assign out_data.word_index  = oidx_reg;
    assign out_data.last_word   = (oidx_reg == 3'd7);

    assign s0   = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
                ^ (w_reg[1] >> 3);
    assign s1   = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
                ^ (w_reg[14] >> 10);
    assign wnew = s1 + w_reg[9] + s0 + w_reg[0];
    assign wt   = w_reg[0];
    assign e    = v_reg[4];
    assign a    = v_reg[0];
    assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    assign ch   = (e & v_reg[5]) ^ (~e & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + sha256_pkg::round_k(t_reg) + wt;
    assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    assign maj  = (a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_LOAD;
            t_reg     <= '0;
            fin_reg   <= 1'b0;
            oidx_reg  <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= sha256_pkg::INITIAL_HASH[255 - 32*i -: 32];
        end
        else
        begin
            unique case (state_reg)
                C_LOAD:
                begin
                    if (wq_valid && wq_data.last)
                    begin
                        fin_reg   <= wq_data.finish;
                        t_reg     <= '0;
                        state_reg <= C_ROUND;
                    end
                end
                C_ROUND:
                begin
                    t_reg <= t_reg + 6'd1;
                    if (t_reg == 6'd63)
                        state_reg <= C_ADD;
                end
                C_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    oidx_reg  <= '0;
                    state_reg <= fin_reg ? C_EMIT : C_LOAD;
                end
                default:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 3'd1;
                        if (oidx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                h_reg[i] <= sha256_pkg::INITIAL_HASH[255 - 32*i -: 32];
                            state_reg <= C_LOAD;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_LOAD && wq_valid)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wq_data.word;
            if (wq_data.last)
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
        end
        else if (state_reg == C_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

`ifndef SYNTHESIS
    a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ROUND && t_reg == 6'd63) |=> state_reg == C_ADD)
        else $error("round count slip");
    a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(oidx_reg))
        else $error("digest index moved while stalled");
    a_load_t0: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_LOAD) |-> t_reg == 6'd0 || t_reg == 6'd63 + 6'd1)
        else $error("round counter not cleared");
`endif

endmodule

[sv/sha256_byte_stream_hasher.sv]
// SHA-256 over a byte stream, one byte per transaction.
// Absorb: one byte per cycle while the 2-word queue has room; a full 64-byte block is then
// compressed in the round core (load, rounds, add) while the next block's bytes fill the queue.
// Finish: 0x80, zeros, 64-bit length fill one or two blocks; then 8 digest words, one per cycle
// while out_ready is high. Reset (rst_n, async low) restores the initial hash, clears the count.
module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_item_t out_data
);

    logic                  fq_valid, fq_ready, qc_valid, qc_ready;
    sha256_pkg::blk_word_t fq_data, qc_data;

    sha256_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .wq_valid (fq_valid),
        .wq_ready (fq_ready),
        .wq_data  (fq_data)
    );

    sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qc_valid),
        .rd_ready (qc_ready),
        .rd_data  (qc_data)
    );

    sha256_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .wq_valid  (qc_valid),
        .wq_ready  (qc_ready),
        .wq_data   (qc_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
